// File: rtl/krt_pkg.sv
// krt_pkg: command and status codes, sequencer states for the keyed record table
// used by krt_store and keyed_record_table_top; no dependencies
`default_nettype none
package krt_pkg;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned KEY_W    = 20;
    localparam int unsigned PRICE_W  = 24;
    localparam int unsigned STOCK_W  = 16;
    localparam int unsigned DELTA_W  = 17;
    localparam int unsigned TOTAL_W  = 47;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned REC_W    = KEY_W + PRICE_W + STOCK_W;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_ADJUST = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_TOTAL  = 3'd4,
        CMD_SORT   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_NEG      = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,   // issue read at index
        S_SCAN_CHK,  // compare key, act on a match
        S_MUL,
        S_ACC,
        S_DEL_RD,
        S_DEL_WR,
        S_SRT_RD0,
        S_SRT_RD1,
        S_SRT_CMP,
        S_SRT_WR,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// File: rtl/keyed_record_table_top.sv
// keyed_record_table_top: sequencer around one record memory and one multiply-add unit
// depends on krt_pkg and krt_store
//
// usage: one request on the input channel (cmd, key, price, stock, delta) gives one
// response on the output channel (status, found price/stock, value sum, entry count).
// the block takes one request at a time; o_ready is low while a request is worked.
// the memory has a single port, so every step is one access:
//   insert, lookup, adjust: a key scan over the n held records
//   delete: key scan, then a read and a write per record moved left
//   total: read, multiply, accumulate per record
//   sort: two reads and a compare per compared pair, n*(n-1)/2 pairs; a swap adds a write
// an empty table answers the non-insert commands without a memory access.
// the response is held in an output register until taken; while the receiver
// stalls the block waits and accepts nothing new.
// reset empties the table at once: the record memory needs no clearing pass,
// positions at or beyond the count are never used.
`default_nettype none
module keyed_record_table_top #(
    parameter int unsigned CAPACITY = 128
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [krt_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [krt_pkg::KEY_W-1:0]     i_item_key,
    input  wire logic [krt_pkg::PRICE_W-1:0]   i_item_price,
    input  wire logic [krt_pkg::STOCK_W-1:0]   i_item_stock,
    input  wire logic signed [krt_pkg::DELTA_W-1:0] i_stock_delta,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [2:0]                         o_status,
    output logic [krt_pkg::PRICE_W-1:0]        o_found_price,
    output logic [krt_pkg::STOCK_W-1:0]        o_found_stock,
    output logic [krt_pkg::TOTAL_W-1:0]        o_value_sum,
    output logic [krt_pkg::COUNT_W-1:0]        o_entry_count
);
    localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned SW  = krt_pkg::STOCK_W;
    localparam int unsigned PW  = krt_pkg::PRICE_W;
    localparam int unsigned KW  = krt_pkg::KEY_W;
    localparam int unsigned ACW = krt_pkg::TOTAL_W + 1;

    krt_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_lim, n_lim;
    logic [2:0]     r_cmd, n_cmd;
    logic [KW-1:0]  r_key, n_key;
    logic [PW-1:0]  r_price, n_price;
    logic [SW-1:0]  r_stock, n_stock;
    logic signed [krt_pkg::DELTA_W-1:0] r_delta, n_delta;
    logic [krt_pkg::REC_W-1:0] r_hold, n_hold;
    logic [PW+SW-1:0] r_prod, n_prod;
    logic [ACW-1:0] r_acc, n_acc;
    logic           r_ovf, n_ovf;
    logic [2:0]     r_st, n_st;
    logic [PW-1:0]  r_fp, n_fp;
    logic [SW-1:0]  r_fs, n_fs;

    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [krt_pkg::REC_W-1:0] mem_wdata, mem_rdata;

    logic [KW-1:0]  rd_key;
    logic [PW-1:0]  rd_price;
    logic [SW-1:0]  rd_stock;
    logic signed [SW+1:0] adj_sum;
    logic [krt_pkg::REC_W-1:0] adj_rec;

    krt_store #(.DEPTH(CAPACITY), .ADDR_W(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    assign rd_key   = mem_rdata[krt_pkg::REC_W-1 -: KW];
    assign rd_price = mem_rdata[SW +: PW];
    assign rd_stock = mem_rdata[SW-1:0];
    assign adj_sum  = $signed({2'b00, rd_stock}) + (SW+2)'(r_delta);
    assign adj_rec  = {rd_key, rd_price, adj_sum[SW-1:0]};

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_lim   = r_lim;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_price = r_price;
        n_stock = r_stock;
        n_delta = r_delta;
        n_hold  = r_hold;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_st    = r_st;
        n_fp    = r_fp;
        n_fs    = r_fs;
        case (r_state)
            krt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_key   = i_item_key;
                    n_price = i_item_price;
                    n_stock = i_item_stock;
                    n_delta = i_stock_delta;
                    n_idx   = '0;
                    n_acc   = '0;
                    n_ovf   = 1'b0;
                    n_st    = krt_pkg::ST_OK;
                    n_fp    = '0;
                    n_fs    = '0;
                    n_state = krt_pkg::S_DONE;
                    if (i_cmd == krt_pkg::CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_st = krt_pkg::ST_FULL;
                        end else begin
                            n_state = krt_pkg::S_SCAN_RD;
                        end
                    end else if (i_cmd <= krt_pkg::CMD_SORT) begin
                        if (r_count == '0) begin
                            n_st = krt_pkg::ST_EMPTY;
                        end else if (i_cmd == krt_pkg::CMD_TOTAL) begin
                            n_state = krt_pkg::S_SCAN_RD;
                        end else if (i_cmd == krt_pkg::CMD_SORT) begin
                            n_lim   = r_count - CW'(1);
                            n_state = (r_count == CW'(1)) ? krt_pkg::S_DONE
                                                          : krt_pkg::S_SRT_RD0;
                        end else begin
                            n_state = krt_pkg::S_SCAN_RD;
                        end
                    end
                end
            end
            krt_pkg::S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    // key not found or walk finished
                    n_state = krt_pkg::S_DONE;
                    if (r_cmd == krt_pkg::CMD_INSERT) begin
                        n_count = r_count + CW'(1);
                    end else if (r_cmd == krt_pkg::CMD_TOTAL) begin
                        if (r_ovf || r_acc[ACW-1]) begin
                            n_st  = krt_pkg::ST_OVERFLOW;
                            n_acc = {1'b0, {(ACW-1){1'b1}}};
                        end
                    end else begin
                        n_st = krt_pkg::ST_NOTFOUND;
                    end
                end else begin
                    n_state = (r_cmd == krt_pkg::CMD_TOTAL) ? krt_pkg::S_MUL
                                                            : krt_pkg::S_SCAN_CHK;
                end
            end
            krt_pkg::S_SCAN_CHK: begin
                if (rd_key == r_key) begin
                    n_state = krt_pkg::S_DONE;
                    case (r_cmd)
                        krt_pkg::CMD_INSERT: n_st = krt_pkg::ST_DUP;
                        krt_pkg::CMD_LOOKUP: begin
                            n_fp = rd_price;
                            n_fs = rd_stock;
                        end
                        krt_pkg::CMD_ADJUST: begin
                            if (adj_sum < 0) begin
                                n_st = krt_pkg::ST_NEG;
                            end else if (adj_sum[SW]) begin
                                n_st = krt_pkg::ST_OVERFLOW;
                            end else begin
                                n_fs = adj_sum[SW-1:0];
                            end
                        end
                        krt_pkg::CMD_DELETE: begin
                            n_idx   = r_idx + CW'(1);
                            n_state = krt_pkg::S_DEL_RD;
                        end
                        default: n_st = krt_pkg::ST_OK;
                    endcase
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = krt_pkg::S_SCAN_RD;
                end
            end
            krt_pkg::S_MUL: begin
                n_prod  = rd_price * rd_stock;
                n_state = krt_pkg::S_ACC;
            end
            krt_pkg::S_ACC: begin
                n_acc   = r_acc + ACW'(r_prod);
                n_ovf   = r_ovf | r_acc[ACW-1];
                n_idx   = r_idx + CW'(1);
                n_state = krt_pkg::S_SCAN_RD;
            end
            krt_pkg::S_DEL_RD: begin
                // idx points at the record to move left
                if (r_idx == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = krt_pkg::S_DONE;
                end else begin
                    n_state = krt_pkg::S_DEL_WR;
                end
            end
            krt_pkg::S_DEL_WR: begin
                n_idx   = r_idx + CW'(1);
                n_state = krt_pkg::S_DEL_RD;
            end
            krt_pkg::S_SRT_RD0: begin
                n_state = krt_pkg::S_SRT_RD1;
            end
            krt_pkg::S_SRT_RD1: begin
                n_hold  = mem_rdata;
                n_state = krt_pkg::S_SRT_CMP;
            end
            krt_pkg::S_SRT_CMP: begin
                // hold = entry j, rdata = entry j+1
                if (r_hold[SW-1:0] < rd_stock) begin
                    n_state = krt_pkg::S_SRT_WR;
                end else begin
                    n_idx = r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_lim) begin
                        n_idx = '0;
                        n_lim = r_lim - CW'(1);
                        n_state = (r_lim == CW'(1)) ? krt_pkg::S_DONE
                                                    : krt_pkg::S_SRT_RD0;
                    end else begin
                        n_state = krt_pkg::S_SRT_RD0;
                    end
                end
                n_hold = (r_hold[SW-1:0] < rd_stock) ? r_hold : mem_rdata;
            end
            krt_pkg::S_SRT_WR: begin
                // second half of the swap: old j goes to j+1
                n_idx = r_idx + CW'(1);
                if (r_idx + CW'(1) == r_lim) begin
                    n_idx = '0;
                    n_lim = r_lim - CW'(1);
                    n_state = (r_lim == CW'(1)) ? krt_pkg::S_DONE : krt_pkg::S_SRT_RD0;
                end else begin
                    n_state = krt_pkg::S_SRT_RD0;
                end
            end
            krt_pkg::S_DONE: begin
                if (i_ready) begin
                    n_state = krt_pkg::S_IDLE;
                end
            end
            default: n_state = krt_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_idx[AW-1:0];
        mem_wdata = {r_key, r_price, r_stock};
        case (r_state)
            krt_pkg::S_SCAN_RD: begin
                if (r_idx == r_count && r_cmd == krt_pkg::CMD_INSERT) begin
                    mem_we = 1'b1;
                end
            end
            krt_pkg::S_SCAN_CHK: begin
                if (rd_key == r_key && r_cmd == krt_pkg::CMD_ADJUST &&
                    adj_sum >= 0 && !adj_sum[SW]) begin
                    mem_we    = 1'b1;
                    mem_wdata = adj_rec;
                end
            end
            krt_pkg::S_DEL_WR: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_idx - CW'(1));
                mem_wdata = mem_rdata;
            end
            krt_pkg::S_SRT_RD0: mem_addr = r_idx[AW-1:0];
            krt_pkg::S_SRT_RD1: mem_addr = AW'(r_idx + CW'(1));
            krt_pkg::S_SRT_CMP: begin
                if (r_hold[SW-1:0] < rd_stock) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                end
            end
            krt_pkg::S_SRT_WR: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_idx + CW'(1));
                mem_wdata = r_hold;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // outputs
    always_comb begin
        o_ready       = (r_state == krt_pkg::S_IDLE);
        o_valid       = (r_state == krt_pkg::S_DONE);
        o_status      = r_st;
        o_found_price = r_fp;
        o_found_stock = r_fs;
        o_value_sum   = (r_cmd == krt_pkg::CMD_TOTAL) ? r_acc[ACW-2:0] : '0;
        o_entry_count = krt_pkg::COUNT_W'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx   <= n_idx;
        r_lim   <= n_lim;
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_price <= n_price;
        r_stock <= n_stock;
        r_delta <= n_delta;
        r_hold  <= n_hold;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_ovf   <= n_ovf;
        r_st    <= n_st;
        r_fp    <= n_fp;
        r_fs    <= n_fs;
    end
endmodule
`default_nettype wire

// File: rtl/krt_store.sv
// krt_store: single-port record memory (key, price, stock packed), registered read
// depends on krt_pkg
`default_nettype none
module krt_store #(
    parameter int unsigned DEPTH  = 128,
    parameter int unsigned ADDR_W = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [ADDR_W-1:0]         i_addr,
    input  wire logic [krt_pkg::REC_W-1:0] i_wdata,
    output logic      [krt_pkg::REC_W-1:0] o_rdata
);
    logic [krt_pkg::REC_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire
